// ===== rtl/rotated_array_search_assert.svh =====
// assertion macros for the rotated array search block
// used inside modules that have clk and rst_n in scope; needs no other file
`ifndef ROTATED_ARRAY_SEARCH_ASSERT_SVH
`define ROTATED_ARRAY_SEARCH_ASSERT_SVH

// same-cycle implication, off during reset
`define RAS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rotated_array_search check failed");

// next-cycle implication, off during reset
`define RAS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rotated_array_search check failed");

`endif

// ===== rtl/rsa_pkg.sv =====
// shared types, constants and the sequencer microcode for the rotated array search
// no dependencies; used by the channel interfaces and the top level
`timescale 1ns / 1ps

package rsa_pkg;

  localparam int DEPTH = 1024;
  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = 10;
  localparam int IX_W  = ((AW > FW) ? AW : FW) + 2;
  localparam int DW    = 32;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_WRITTEN   = 2'd0,
    STAT_FOUND     = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CHECK,
    ST_RDMID,
    ST_CMP,
    ST_DECIDE,
    ST_RIGHT,
    ST_FIN
  } step_t;

  typedef enum logic [1:0] {
    A_WR,
    A_LO,
    A_MID,
    A_HI
  } asel_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_ACCEPT,
    C_WRITE,
    C_EMPTY,
    C_HIT,
    C_LEFT,
    C_OUTFREE
  } cond_t;

  typedef enum logic [1:0] {
    U_NONE,
    U_LOAD,
    U_LEFT,
    U_RIGHT
  } upd_t;

  typedef enum logic [1:0] {
    R_NONE,
    R_WRITE,
    R_MISS,
    R_HIT
  } res_t;

  // one control word per step: taken branch goes to jmp, else to seq
  typedef struct packed {
    asel_t asel;
    cond_t cond;
    step_t jmp;
    step_t seq;
    logic  wr;
    logic  ld_mid;
    logic  cap_vlo;
    logic  cap_vmid;
    upd_t  upd;
    res_t  res;
  } ucw_t;

  function automatic ucw_t ucode(step_t s);
    ucw_t w;
    w = '{asel: A_WR, cond: C_ACCEPT, jmp: ST_LOAD, seq: ST_IDLE, wr: 1'b0,
          ld_mid: 1'b0, cap_vlo: 1'b0, cap_vmid: 1'b0, upd: U_NONE, res: R_NONE};
    case (s)
      ST_IDLE: begin
        w.cond = C_ACCEPT; w.jmp = ST_LOAD; w.seq = ST_IDLE;
      end
      ST_LOAD: begin
        w.cond = C_WRITE; w.jmp = ST_FIN; w.seq = ST_CHECK;
        w.wr = 1'b1; w.upd = U_LOAD; w.res = R_WRITE;
      end
      ST_CHECK: begin
        w.asel = A_LO; w.cond = C_EMPTY; w.jmp = ST_FIN; w.seq = ST_RDMID;
        w.ld_mid = 1'b1; w.res = R_MISS;
      end
      ST_RDMID: begin
        w.asel = A_MID; w.cond = C_ALWAYS; w.jmp = ST_CMP; w.seq = ST_CMP;
        w.cap_vlo = 1'b1;
      end
      ST_CMP: begin
        w.asel = A_HI; w.cond = C_HIT; w.jmp = ST_FIN; w.seq = ST_DECIDE;
        w.cap_vmid = 1'b1; w.res = R_HIT;
      end
      ST_DECIDE: begin
        w.asel = A_HI; w.cond = C_LEFT; w.jmp = ST_CHECK; w.seq = ST_RIGHT;
        w.upd = U_LEFT;
      end
      ST_RIGHT: begin
        w.asel = A_HI; w.cond = C_ALWAYS; w.jmp = ST_CHECK; w.seq = ST_CHECK;
        w.upd = U_RIGHT;
      end
      ST_FIN: begin
        w.cond = C_OUTFREE; w.jmp = ST_IDLE; w.seq = ST_FIN;
      end
      default: begin
        w.cond = C_ALWAYS; w.jmp = ST_IDLE; w.seq = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/rsa_req_if.sv =====
// request channel of the rotated array search: valid, ready and the request fields
// depends on rsa_pkg
`timescale 1ns / 1ps

interface rsa_req_if;
  logic                            valid;
  logic                            ready;
  rsa_pkg::op_t                    op;
  logic signed [rsa_pkg::DW-1:0]   value;
  logic        [rsa_pkg::FW-1:0]   first_index;
  logic        [rsa_pkg::FW-1:0]   last_index;

  modport source (output valid, op, value, first_index, last_index, input ready);
  modport sink   (input valid, op, value, first_index, last_index, output ready);
endinterface

// ===== rtl/rsa_rsp_if.sv =====
// result channel of the rotated array search: valid, ready, status and position
// depends on rsa_pkg
`timescale 1ns / 1ps

interface rsa_rsp_if;
  logic                       valid;
  logic                       ready;
  rsa_pkg::status_t           status;
  logic [rsa_pkg::FW-1:0]     position;

  modport source (output valid, status, position, input ready);
  modport sink   (input valid, status, position, output ready);
endinterface

// ===== rtl/rotated_array_search.sv =====
// rotated array search top level: table memory, microcoded sequencer and datapath
// depends on rsa_pkg, rsa_req_if, rsa_rsp_if and rotated_array_search_assert.svh
//
//  channel   dir  handshake      payload
//  in_chan   in   valid/ready    op, value, first_index, last_index
//  out_chan  out  valid/ready    status, position
//
//  a write goes from load to fin for its result; a search loads lo and hi, then
//  repeats check, rdmid, cmp and decide, plus right when the lo value is not
//  below the mid value, until cmp finds a match or check finds the range empty
//  the per-step cost is set by the single-port table memory: lo, mid and hi are
//  read one after another through its registered read port
//  one request at a time; the next is taken while the last result waits in the
//  output register; reset clears control state only, table contents are kept
`timescale 1ns / 1ps

`include "rotated_array_search_assert.svh"

module rotated_array_search (
  input  logic      clk,
  input  logic      rst_n,
  rsa_req_if.sink   in_chan,
  rsa_rsp_if.source out_chan
);

  localparam int AW   = rsa_pkg::AW;
  localparam int FW   = rsa_pkg::FW;
  localparam int IX_W = rsa_pkg::IX_W;
  localparam int DW   = rsa_pkg::DW;

  rsa_pkg::step_t step_r, step_nxt;
  rsa_pkg::ucw_t  uc;
  logic           taken;

  rsa_pkg::op_t               op_r;
  logic signed [DW-1:0]       key_r;
  logic        [FW-1:0]       first_r;
  logic        [FW-1:0]       last_r;
  logic signed [IX_W-1:0]     lo_r;
  logic signed [IX_W-1:0]     hi_r;
  logic        [AW-1:0]       mid_r;
  logic signed [DW-1:0]       vlo_r;
  logic signed [DW-1:0]       vmid_r;
  rsa_pkg::status_t           pend_status_r;
  logic        [FW-1:0]       pend_pos_r;
  rsa_pkg::status_t           res_status_r;
  logic        [FW-1:0]       res_pos_r;
  logic                       out_valid_r;

  logic signed [DW-1:0]       mem [rsa_pkg::DEPTH];
  logic signed [DW-1:0]       mem_q;
  logic        [AW-1:0]       mem_addr;
  logic                       mem_we;

  logic                       accept;
  logic                       out_free;
  logic signed [IX_W-1:0]     span;
  logic signed [IX_W-1:0]     mid_full;
  logic signed [IX_W-1:0]     mid_ext;
  logic signed [IX_W-1:0]     last_clamped;
  logic                       wr_in_range;

  assign accept   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  assign in_chan.ready     = (step_r == rsa_pkg::ST_IDLE);
  assign out_chan.valid    = out_valid_r;
  assign out_chan.status   = res_status_r;
  assign out_chan.position = res_pos_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= rsa_pkg::ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_comb begin
    uc = rsa_pkg::ucode(step_r);
    case (uc.cond)
      rsa_pkg::C_ALWAYS:  taken = 1'b1;
      rsa_pkg::C_ACCEPT:  taken = accept;
      rsa_pkg::C_WRITE:   taken = (op_r == rsa_pkg::OP_WRITE);
      rsa_pkg::C_EMPTY:   taken = (lo_r > hi_r);
      rsa_pkg::C_HIT:     taken = (key_r == mem_q);
      rsa_pkg::C_LEFT:    taken = (vlo_r < vmid_r);
      rsa_pkg::C_OUTFREE: taken = out_free;
      default:            taken = 1'b0;
    endcase
    step_nxt = taken ? uc.jmp : uc.seq;
  end

  // address and index arithmetic
  assign span         = hi_r - lo_r;
  assign mid_full     = lo_r + (span >>> 1);
  assign mid_ext      = $signed(IX_W'(mid_r));
  assign last_clamped = (32'(last_r) > 32'(rsa_pkg::DEPTH - 1)) ?
                        IX_W'(rsa_pkg::DEPTH - 1) : $signed(IX_W'(last_r));
  assign wr_in_range  = (32'(first_r) < 32'(rsa_pkg::DEPTH));
  assign mem_we       = uc.wr && (op_r == rsa_pkg::OP_WRITE) && wr_in_range;

  always_comb begin
    case (uc.asel)
      rsa_pkg::A_WR:  mem_addr = first_r[AW-1:0];
      rsa_pkg::A_LO:  mem_addr = lo_r[AW-1:0];
      rsa_pkg::A_MID: mem_addr = mid_r;
      rsa_pkg::A_HI:  mem_addr = hi_r[AW-1:0];
      default:        mem_addr = mid_r;
    endcase
  end

  // table memory, single port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= key_r;
    end
    mem_q <= mem[mem_addr];
  end

  // request capture and search datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_chan.op;
      key_r   <= in_chan.value;
      first_r <= in_chan.first_index;
      last_r  <= in_chan.last_index;
    end
    if (uc.ld_mid) begin
      mid_r <= mid_full[AW-1:0];
    end
    if (uc.cap_vlo) begin
      vlo_r <= mem_q;
    end
    if (uc.cap_vmid) begin
      vmid_r <= mem_q;
    end
    case (uc.upd)
      rsa_pkg::U_LOAD: begin
        lo_r <= $signed(IX_W'(first_r));
        hi_r <= last_clamped;
      end
      rsa_pkg::U_LEFT: begin
        if (taken) begin
          if (vlo_r <= key_r && key_r < vmid_r) begin
            hi_r <= mid_ext - IX_W'(1);
          end else begin
            lo_r <= mid_ext + IX_W'(1);
          end
        end
      end
      rsa_pkg::U_RIGHT: begin
        if (vmid_r <= key_r && key_r <= mem_q) begin
          lo_r <= mid_ext + IX_W'(1);
        end else begin
          hi_r <= mid_ext - IX_W'(1);
        end
      end
      default: begin
      end
    endcase
    if (taken) begin
      case (uc.res)
        rsa_pkg::R_WRITE: begin
          pend_status_r <= rsa_pkg::STAT_WRITTEN;
          pend_pos_r    <= '0;
        end
        rsa_pkg::R_MISS: begin
          pend_status_r <= rsa_pkg::STAT_NOT_FOUND;
          pend_pos_r    <= '0;
        end
        rsa_pkg::R_HIT: begin
          pend_status_r <= rsa_pkg::STAT_FOUND;
          pend_pos_r    <= FW'(mid_r);
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_r == rsa_pkg::ST_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_r == rsa_pkg::ST_FIN && out_free) begin
      res_status_r <= pend_status_r;
      res_pos_r    <= pend_pos_r;
    end
  end

  `RAS_ASSERT_NXT(a_accept_loads, accept, step_r == rsa_pkg::ST_LOAD)
  `RAS_ASSERT_IMP(a_pos_zero_on_miss,
                  out_valid_r && res_status_r != rsa_pkg::STAT_FOUND, res_pos_r == '0)
  `RAS_ASSERT_IMP(a_range_live, step_r == rsa_pkg::ST_RDMID, lo_r <= hi_r)
  `RAS_ASSERT_NXT(a_fin_delivers, step_r == rsa_pkg::ST_FIN && !out_valid_r,
                  out_valid_r && step_r == rsa_pkg::ST_IDLE)
  `RAS_ASSERT_IMP(a_write_only_load, mem_we,
                  step_r == rsa_pkg::ST_LOAD && op_r == rsa_pkg::OP_WRITE)

endmodule
